/* design/vru_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vru_pkg
// shared types and constants of the vector refraction pipeline
// ----------------------------------------------------------------------------
package vru_pkg;

    localparam int IN_W       = 16;
    localparam int PROD1_W    = 32;
    localparam int DOT_W      = 34;
    localparam int D24_W      = 29;
    localparam int ROOT_W     = 29;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int SUM_W      = RAD_W + 1;
    localparam int REM_W      = ROOT_W + 2;
    localparam int K_W        = 31;
    localparam int PROD_W     = IN_W + K_W;
    localparam int A_W        = 47;
    localparam int QBITS      = 17;
    localparam int DEN_SHIFT  = 12;
    localparam int HALF_SHIFT = 11;
    localparam int ONE_SHIFT  = 48;
    localparam int RAD_SHIFT  = 24;
    localparam int IC_SHIFT   = 24;
    localparam int FRONT_LAT  = 4;
    localparam int DIV_LAT    = QBITS + 5;
    localparam int LAT_TOTAL  = FRONT_LAT + ROOT_W + 1 + DIV_LAT;

    localparam logic signed [IN_W-1:0] Q_MAX = 16'sh7FFF;
    localparam logic signed [IN_W-1:0] Q_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [IN_W-1:0] ix;
        logic signed [IN_W-1:0] iy;
        logic signed [IN_W-1:0] iz;
        logic signed [IN_W-1:0] nx;
        logic signed [IN_W-1:0] ny;
        logic signed [IN_W-1:0] nz;
        logic        [IN_W-1:0] n;
    } vec_t;

    typedef struct packed {
        vec_t                    v;
        logic signed [D24_W-1:0] d24;
        logic        [RAD_W-1:0] rad;
        logic                    nt;
    } front_t;

    typedef struct packed {
        vec_t                    v;
        logic signed [D24_W-1:0] d24;
        logic                    nt;
    } side_t;

endpackage

/* design/vru_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vru_front
// dot product, rounded cosine term and radicand, four register stages
// ----------------------------------------------------------------------------
module vru_front (
    input  logic            clk,
    input  logic            en_first,
    input  logic            en,
    input  vru_pkg::vec_t   in_vec,
    output vru_pkg::front_t front
);
    import vru_pkg::*;

    vec_t                      v1_reg, v2_reg, v3_reg;
    logic signed [PROD1_W-1:0] px_reg, py_reg, pz_reg;
    logic        [PROD1_W-1:0] nn_reg;
    logic signed [D24_W-1:0]   d24_reg, d24_3_reg;
    logic signed [SUM_W-1:0]   nnm_reg, nnm_3_reg;
    logic signed [RAD_W-1:0]   dd_reg;
    front_t                    front_reg;

    logic signed [DOT_W-1:0]   dot_next;
    logic signed [D24_W-1:0]   d24_next;
    logic signed [SUM_W-1:0]   nnm_next;
    logic signed [SUM_W-1:0]   rad_next;
    logic                      nt_next;

    function automatic logic signed [D24_W-1:0] round_d24(input logic signed [DOT_W-1:0] v);
        logic [DOT_W-1:0] mag;
        logic [DOT_W-1:0] r;
        mag = v[DOT_W-1] ? DOT_W'(-v) : DOT_W'(v);
        r   = (mag + DOT_W'(8)) >> 4;
        return v[DOT_W-1] ? -$signed(r[D24_W-1:0]) : $signed(r[D24_W-1:0]);
    endfunction

    always_comb
    begin
        dot_next = DOT_W'(px_reg) + DOT_W'(py_reg) + DOT_W'(pz_reg);
        d24_next = round_d24(-dot_next);
        nnm_next = $signed({3'b000, nn_reg, 24'd0})
                 - $signed(SUM_W'(1) << ONE_SHIFT);
        rad_next = nnm_3_reg + $signed({1'b0, dd_reg});
        nt_next  = (v3_reg.n == '0) || rad_next[SUM_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en_first)
        begin
            v1_reg <= in_vec;
            px_reg <= in_vec.ix * in_vec.nx;
            py_reg <= in_vec.iy * in_vec.ny;
            pz_reg <= in_vec.iz * in_vec.nz;
            nn_reg <= in_vec.n * in_vec.n;
        end
        if (en)
        begin
            v2_reg          <= v1_reg;
            d24_reg         <= d24_next;
            nnm_reg         <= nnm_next;
            v3_reg          <= v2_reg;
            d24_3_reg       <= d24_reg;
            nnm_3_reg       <= nnm_reg;
            dd_reg          <= d24_reg * d24_reg;
            front_reg.v     <= v3_reg;
            front_reg.d24   <= d24_3_reg;
            front_reg.nt    <= nt_next;
            front_reg.rad   <= nt_next ? '0 : rad_next[RAD_W-1:0];
        end
    end

    assign front = front_reg;

endmodule

/* design/vru_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vru_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module vru_sqrt (
    input  logic                       clk,
    input  logic                       en,
    input  vru_pkg::front_t            front,
    output vru_pkg::side_t             side,
    output logic [vru_pkg::ROOT_W-1:0] root
);
    import vru_pkg::*;

    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_next [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [ROOT_W-1:0] root_next[ROOT_W];
    logic [RAD_W-1:0]  x_reg    [ROOT_W];
    logic [RAD_W-1:0]  x_next   [ROOT_W];
    side_t             side_reg [ROOT_W];
    side_t             side_in;

    assign side_in.v   = front.v;
    assign side_in.d24 = front.d24;
    assign side_in.nt  = front.nt;

    always_comb
    begin
        logic [REM_W+1:0]  cand;
        logic [REM_W+1:0]  trial;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  x_in;
        for (int i = 0; i < ROOT_W; i++)
        begin
            if (i == 0)
            begin
                rem_in  = '0;
                root_in = '0;
                x_in    = front.rad;
            end
            else
            begin
                rem_in  = rem_reg[i-1];
                root_in = root_reg[i-1];
                x_in    = x_reg[i-1];
            end
            cand      = {rem_in, x_in[RAD_W-1 -: 2]};
            trial     = {2'b00, root_in, 2'b01};
            x_next[i] = x_in << 2;
            if (cand >= trial)
            begin
                rem_next[i]  = REM_W'(cand - trial);
                root_next[i] = {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = cand[REM_W-1:0];
                root_next[i] = {root_in[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < ROOT_W; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                x_reg[i]    <= x_next[i];
                side_reg[i] <= (i == 0) ? side_in : side_reg[i-1];
            end
        end
    end

    assign side = side_reg[ROOT_W-1];
    assign root = root_reg[ROOT_W-1];

endmodule

/* design/vru_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vru_div
// one output component: numerator, rounded pipelined divide by n, saturation
// ----------------------------------------------------------------------------
module vru_div (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [vru_pkg::IN_W-1:0] ic,
    input  logic signed [vru_pkg::IN_W-1:0] nc,
    input  logic signed [vru_pkg::K_W-1:0]  k,
    input  logic        [vru_pkg::IN_W-1:0] n,
    input  logic                            nt,
    output logic signed [vru_pkg::IN_W-1:0] res
);
    import vru_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [IN_W-1:0]   ic_p_reg;
    logic        [IN_W-1:0]   n_p_reg, n_m_reg, n_a_reg, n_d_reg;
    logic                     nt_p_reg, nt_m_reg, nt_a_reg, nt_d_reg;
    logic signed [PROD_W-1:0] num_reg;
    logic        [A_W-1:0]    a_reg, rem_d_reg;
    logic                     neg_a_reg, neg_d_reg, ovf_d_reg;

    logic [A_W-1:0]   rem_reg  [QBITS];
    logic [A_W-1:0]   rem_next [QBITS];
    logic [QBITS-1:0] q_reg    [QBITS];
    logic [QBITS-1:0] q_next   [QBITS];
    logic [IN_W-1:0]  n_b_reg  [QBITS];
    logic             neg_b_reg[QBITS];
    logic             ovf_b_reg[QBITS];
    logic             nt_b_reg [QBITS];

    logic signed [PROD_W-1:0] num_next;
    logic        [A_W-1:0]    mag_next;
    logic                     ovf_next;
    logic        [QBITS-1:0]  qf;
    logic signed [IN_W-1:0]   res_next;
    logic signed [IN_W-1:0]   res_reg;

    always_comb
    begin
        num_next = $signed({{(PROD_W-IN_W){ic_p_reg[IN_W-1]}}, ic_p_reg}) <<< IC_SHIFT;
        num_next = num_next - prod_reg;
        mag_next = num_reg[PROD_W-1] ? A_W'(-num_reg) : A_W'(num_reg);
        ovf_next = a_reg[A_W-1:QBITS] >= (A_W-QBITS)'({n_a_reg, 12'd0});
    end

    always_comb
    begin
        logic [A_W-1:0]   rem_in;
        logic [QBITS-1:0] q_in;
        logic [IN_W-1:0]  n_in;
        logic [A_W-1:0]   sh;
        for (int j = 0; j < QBITS; j++)
        begin
            if (j == 0)
            begin
                rem_in = rem_d_reg;
                q_in   = '0;
                n_in   = n_d_reg;
            end
            else
            begin
                rem_in = rem_reg[j-1];
                q_in   = q_reg[j-1];
                n_in   = n_b_reg[j-1];
            end
            sh = A_W'(n_in) << (DEN_SHIFT + QBITS - 1 - j);
            if (rem_in >= sh)
            begin
                rem_next[j] = rem_in - sh;
                q_next[j]   = {q_in[QBITS-2:0], 1'b1};
            end
            else
            begin
                rem_next[j] = rem_in;
                q_next[j]   = {q_in[QBITS-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        qf = q_reg[QBITS-1];
        if (nt_b_reg[QBITS-1])
        begin
            res_next = '0;
        end
        else if (neg_b_reg[QBITS-1])
        begin
            if (ovf_b_reg[QBITS-1] || (qf > QBITS'(32768)))
                res_next = Q_MIN;
            else
                res_next = -$signed(qf[IN_W-1:0]);
        end
        else
        begin
            if (ovf_b_reg[QBITS-1] || (qf > QBITS'(32767)))
                res_next = Q_MAX;
            else
                res_next = $signed(qf[IN_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= nc * k;
            ic_p_reg  <= ic;
            n_p_reg   <= n;
            nt_p_reg  <= nt;
            num_reg   <= num_next;
            n_m_reg   <= n_p_reg;
            nt_m_reg  <= nt_p_reg;
            a_reg     <= mag_next + A_W'({n_m_reg, 11'd0});
            neg_a_reg <= num_reg[PROD_W-1];
            n_a_reg   <= n_m_reg;
            nt_a_reg  <= nt_m_reg;
            rem_d_reg <= a_reg;
            ovf_d_reg <= ovf_next;
            neg_d_reg <= neg_a_reg;
            n_d_reg   <= n_a_reg;
            nt_d_reg  <= nt_a_reg;
            for (int j = 0; j < QBITS; j++)
            begin
                rem_reg[j]   <= rem_next[j];
                q_reg[j]     <= q_next[j];
                n_b_reg[j]   <= (j == 0) ? n_d_reg   : n_b_reg[j-1];
                neg_b_reg[j] <= (j == 0) ? neg_d_reg : neg_b_reg[j-1];
                ovf_b_reg[j] <= (j == 0) ? ovf_d_reg : ovf_b_reg[j-1];
                nt_b_reg[j]  <= (j == 0) ? nt_d_reg  : nt_b_reg[j-1];
            end
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

/* design/vector_refraction_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_refraction_unit
// Snell refraction of a direction vector in fixed point
// ----------------------------------------------------------------------------
// Takes one beat per clock while the output is not stalled and returns the
// results in order; the depth comes from the 29-stage square-root pipeline and
// the 17-stage divider per component. A stall at the output freezes the whole
// pipeline, while an empty first stage still takes a new beat.
module vector_refraction_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [vru_pkg::IN_W-1:0] incident_x,
    input  logic signed [vru_pkg::IN_W-1:0] incident_y,
    input  logic signed [vru_pkg::IN_W-1:0] incident_z,
    input  logic signed [vru_pkg::IN_W-1:0] normal_x,
    input  logic signed [vru_pkg::IN_W-1:0] normal_y,
    input  logic signed [vru_pkg::IN_W-1:0] normal_z,
    input  logic        [vru_pkg::IN_W-1:0] rel_index,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [vru_pkg::IN_W-1:0] out_x,
    output logic signed [vru_pkg::IN_W-1:0] out_y,
    output logic signed [vru_pkg::IN_W-1:0] out_z,
    output logic                            no_transmission
);
    import vru_pkg::*;

    logic [LAT_TOTAL-1:0] v_reg;
    logic [DIV_LAT:0]     nt_reg;
    logic                 en;
    vec_t                 in_vec;
    front_t               front;
    side_t                side;
    logic [ROOT_W-1:0]    root;
    logic signed [K_W-1:0] k_reg;
    vec_t                 vk_reg;
    logic                 ntk_reg;

    assign en       = !v_reg[LAT_TOTAL-1] || out_ready;
    assign in_ready = en || !v_reg[0];

    assign in_vec.ix = incident_x;
    assign in_vec.iy = incident_y;
    assign in_vec.iz = incident_z;
    assign in_vec.nx = normal_x;
    assign in_vec.ny = normal_y;
    assign in_vec.nz = normal_z;
    assign in_vec.n  = rel_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (in_ready)
                v_reg[0] <= in_valid;
            if (en)
                v_reg[LAT_TOTAL-1:1] <= v_reg[LAT_TOTAL-2:0];
        end
    end

    vru_front u_front (
        .clk      (clk),
        .en_first (in_ready),
        .en       (en),
        .in_vec   (in_vec),
        .front    (front)
    );

    vru_sqrt u_sqrt (
        .clk   (clk),
        .en    (en),
        .front (front),
        .side  (side),
        .root  (root)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_reg   <= $signed({2'b00, root}) - $signed({{2{side.d24[D24_W-1]}}, side.d24});
            vk_reg  <= side.v;
            ntk_reg <= side.nt;
            nt_reg  <= {nt_reg[DIV_LAT-1:0], side.nt};
        end
    end

    vru_div u_div_x (
        .clk (clk),
        .en  (en),
        .ic  (vk_reg.ix),
        .nc  (vk_reg.nx),
        .k   (k_reg),
        .n   (vk_reg.n),
        .nt  (ntk_reg),
        .res (out_x)
    );

    vru_div u_div_y (
        .clk (clk),
        .en  (en),
        .ic  (vk_reg.iy),
        .nc  (vk_reg.ny),
        .k   (k_reg),
        .n   (vk_reg.n),
        .nt  (ntk_reg),
        .res (out_y)
    );

    vru_div u_div_z (
        .clk (clk),
        .en  (en),
        .ic  (vk_reg.iz),
        .nc  (vk_reg.nz),
        .k   (k_reg),
        .n   (vk_reg.n),
        .nt  (ntk_reg),
        .res (out_z)
    );

    assign out_valid       = v_reg[LAT_TOTAL-1];
    assign no_transmission = nt_reg[DIV_LAT];

endmodule

/* design/vru_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vru_checker
// port-level checks of the refraction unit, bound to the top level
// ----------------------------------------------------------------------------
module vru_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic signed [vru_pkg::IN_W-1:0] out_x,
    input logic signed [vru_pkg::IN_W-1:0] out_y,
    input logic signed [vru_pkg::IN_W-1:0] out_z,
    input logic                            no_transmission
);

    // blocked ray gives a zero vector
    a_nt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_transmission |-> out_x == '0 && out_y == '0 && out_z == '0)
        else $error("blocked ray with nonzero vector");

    // free output side never blocks the input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled with free output");

    // input stalls only while a result beat waits
    a_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("ready dropped unexpectedly");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
            && $stable(out_z) && $stable(no_transmission))
        else $error("stalled result changed");

endmodule

bind vector_refraction_unit vru_checker u_vru_checker (.*);

/* tb/vector_refraction_unit_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_refraction_unit_checker
// watches both channels, predicts each refracted vector and compares it
// ----------------------------------------------------------------------------
// Every accepted input beat is run through a fixed-point model of the
// refraction: dot product, rounded d, radicand, floor square root, and the
// rounded, saturated division by the index. Expected vectors queue in order
// and each accepted output beat is compared field by field with the oldest.
// ----------------------------------------------------------------------------
module vector_refraction_unit_checker (
    input  logic        clk,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [15:0] incident_x,
    input  logic [15:0] incident_y,
    input  logic [15:0] incident_z,
    input  logic [15:0] normal_x,
    input  logic [15:0] normal_y,
    input  logic [15:0] normal_z,
    input  logic [15:0] rel_index,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] out_x,
    input  logic [15:0] out_y,
    input  logic [15:0] out_z,
    input  logic        no_transmission,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic        nt;
    } refracted_t;

    refracted_t refracted_q[$];

    initial fail_count = 0;
    assign pending = refracted_q.size();

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic [15:0] divide_saturate(input longint num, input longint den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        if (num < 0)
            return (q > 32768) ? 16'h8000 : 16'(-longint'(q));
        return (q > 32767) ? 16'h7FFF : 16'(q);
    endfunction

    function automatic refracted_t refract(input logic [15:0] i[3], input logic [15:0] nv[3],
                                           input logic [15:0] idx);
        longint ic[3];
        longint nc[3];
        longint n;
        longint dot28;
        longint d24;
        longint rad;
        longint k;
        longint mag;
        logic [15:0] comp[3];
        refracted_t r;
        n = idx;
        for (int j = 0; j < 3; j++)
        begin
            ic[j] = longint'($signed(i[j]));
            nc[j] = longint'($signed(nv[j]));
        end
        dot28 = ic[0] * nc[0] + ic[1] * nc[1] + ic[2] * nc[2];
        mag = (dot28 < 0) ? -dot28 : dot28;
        d24 = (mag + 8) >>> 4;
        if (dot28 > 0)
            d24 = -d24;
        rad = n * n * (64'sd1 << 24) - (64'sd1 << 48) + d24 * d24;
        r = '0;
        if (n == 0 || rad < 0)
        begin
            r.nt = 1'b1;
            return r;
        end
        k = longint'(floor_sqrt(rad)) - d24;
        for (int j = 0; j < 3; j++)
            comp[j] = divide_saturate(ic[j] * (64'sd1 << 24) - nc[j] * k, n * 4096);
        r.x = comp[0];
        r.y = comp[1];
        r.z = comp[2];
        return r;
    endfunction

    always @(posedge clk)
    begin
        refracted_t got;
        refracted_t want;
        if (in_valid && in_ready)
            refracted_q.push_back(refract('{incident_x, incident_y, incident_z},
                                          '{normal_x, normal_y, normal_z}, rel_index));
        if (out_valid && out_ready)
        begin
            got = '{out_x, out_y, out_z, no_transmission};
            if (refracted_q.size() == 0)
                report("output beat with nothing expected");
            else
            begin
                want = refracted_q.pop_front();
                if (got.x !== want.x)
                    report($sformatf("out_x %h expected %h", got.x, want.x));
                if (got.y !== want.y)
                    report($sformatf("out_y %h expected %h", got.y, want.y));
                if (got.z !== want.z)
                    report($sformatf("out_z %h expected %h", got.z, want.z));
                if (got.nt !== want.nt)
                    report($sformatf("no_transmission %b expected %b", got.nt, want.nt));
            end
        end
    end

endmodule

/* tb/vector_refraction_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_refraction_unit_test
// stimulus and verdict for the vector refraction unit
// ----------------------------------------------------------------------------
// Drives directed corner vectors and indices, then random unit-like and raw
// vectors with random gaps on the input and random stalls on the output. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module vector_refraction_unit_test;

    localparam int RANDOM_BEATS = 1200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] incident_x = '0;
    logic [15:0] incident_y = '0;
    logic [15:0] incident_z = '0;
    logic [15:0] normal_x = '0;
    logic [15:0] normal_y = '0;
    logic [15:0] normal_z = '0;
    logic [15:0] rel_index = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic [15:0] out_z;
    logic        no_transmission;
    int          fail_count;
    int          pending;
    logic        stimulus_done = 1'b0;

    always #4 clk = ~clk;

    vector_refraction_unit dut (.*);

    vector_refraction_unit_checker checker_inst (.*);

    task automatic send_beat(input logic [15:0] ix, input logic [15:0] iy,
                             input logic [15:0] iz, input logic [15:0] nx,
                             input logic [15:0] ny, input logic [15:0] nz,
                             input logic [15:0] idx);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        incident_x <= ix;
        incident_y <= iy;
        incident_z <= iz;
        normal_x   <= nx;
        normal_y   <= ny;
        normal_z   <= nz;
        rel_index  <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // rough unit vector component, signed Q2.14
    function automatic logic [15:0] unit_part();
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic logic [15:0] pick_index();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(1, 4095));
            default: return 16'($urandom_range(3000, 9000));
        endcase
    endfunction

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // straight through, grazing, total reflection, extremes, zero index
        send_beat(16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h4000, 16'h1000);
        send_beat(16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h4000, 16'h1555);
        send_beat(16'h2D41, 16'h0000, 16'hD2BF, 16'h0000, 16'h0000, 16'h4000, 16'h0AAB);
        send_beat(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0800);
        send_beat(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h1000);
        send_beat(16'h2D41, 16'h0000, 16'hD2BF, 16'h0000, 16'h0000, 16'h4000, 16'h0000);
        send_beat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        send_beat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
        send_beat(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001);
        send_beat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0400);
        send_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h1000);
        send_beat(16'hC000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0001);
        send_beat(16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h8000);
        for (int b = 0; b < RANDOM_BEATS; b++)
        begin
            if ($urandom_range(0, 4) == 0)
                send_beat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom));
            else
                send_beat(unit_part(), unit_part(), unit_part(), unit_part(),
                          unit_part(), unit_part(), pick_index());
        end
        in_valid      <= 1'b0;
        stimulus_done <= 1'b1;
    end

    // output stall pattern with stretches of full throughput
    initial
    begin
        int stall;
        forever
        begin
            @(negedge clk);
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
        end
    end

    initial
    begin
        wait (stimulus_done);
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (fail_count == 0)
            $display("vector_refraction_unit_test OK");
        else
            $display("vector_refraction_unit_test NOT OK");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("vector_refraction_unit_test NOT OK");
        $finish;
    end

endmodule
